[rtl/crs_pkg.sv]
package crs_pkg;

  localparam int MaxItems   = 64;
  localparam int ValueBits  = 16;
  localparam int StoreDepth = 64;
  localparam int AddrBits   = $clog2(StoreDepth);
  localparam int CntBits    = $clog2(StoreDepth + 1);

  typedef logic [AddrBits-1:0]  addr_t;
  typedef logic [CntBits-1:0]   cnt_t;
  typedef logic [ValueBits-1:0] val_t;

  typedef struct packed {
    logic [15:0] value;
    logic        is_final;
  } in_req_t;

  typedef struct packed {
    logic [15:0] sorted_value;
    logic        end_of_set;
  } out_req_t;

  // Sequencer codes
  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_HEAD  = 3'd1;
  localparam logic [2:0] ST_FIRST = 3'd2;
  localparam logic [2:0] ST_RUN   = 3'd3;
  localparam logic [2:0] ST_PUT   = 3'd4;
  localparam logic [2:0] ST_ERD   = 3'd5;
  localparam logic [2:0] ST_EWT   = 3'd6;

endpackage

[rtl/comparison_rank_sorter_core.sv]
// Comparison counting sorter.
//
// Input channel (in_valid_i/in_ready_o, in_req_i): one unsigned value per
// request. A set closes on a request with is_final set, or when the store
// holds MaxItems values. The set is then ranked and emitted.
// Output channel (out_valid_o/out_ready_i, out_req_o): the values of the
// set in ascending order, equal values in arrival order, end_of_set on the
// largest one.
//
// Sequence for a set of n values: the load takes one value per request,
// then each pass a = 0..n-1 runs the states HEAD, FIRST and PUT around
// n-1-a compares in RUN, then each result takes a sorted store read (ERD)
// and an output load (EWT). The compare pass is set by the single read
// port of the value and rank memories: one pair per cycle.
// in_ready_o is high only while loading; the sort runs one set at a time.
// The output register decouples the receiver: a stalled receiver holds
// emission, and the next set may start loading while the last result waits.
// Reset clears the sequencer, the item count and the output valid; the
// memories need no clearing since each set writes before it reads.
module comparison_rank_sorter_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  crs_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output crs_pkg::out_req_t out_req_o
);
  import crs_pkg::*;

  // Storage: values, partial ranks, values placed at their rank
  val_t  vmem [StoreDepth];
  addr_t rmem [StoreDepth];
  val_t  smem [StoreDepth];

  logic [2:0] state_q, state_d;
  cnt_t       cnt_q, cnt_d;     // values loaded so far
  cnt_t       n_q, n_d;         // size of the set being sorted
  addr_t      a_q, a_d;         // current pass (earlier element)
  cnt_t       b_q, b_d;         // next later element to read
  addr_t      cb_q, cb_d;       // element whose data arrives this cycle
  val_t       va_q, va_d;       // value of element a
  addr_t      ra_q, ra_d;       // running rank of element a
  addr_t      k_q, k_d;         // emit index

  out_req_t   out_q, out_d;
  logic       out_vld_q, out_vld_d;

  // Memory controls
  logic  rd_en, vwr_en, rwr_en, swr_en, srd_en;
  addr_t rd_addr, vwr_addr, srd_addr;
  val_t  vwr_data, vmem_rdata, smem_rdata;
  addr_t rwr_data, rmem_rdata;

  // Compare datapath
  logic  in_acc, gt, first_pass;
  addr_t rb;
  logic  out_load, last_emit;

  assign in_ready_o  = (state_q == ST_LOAD);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_vld_q;
  assign out_req_o   = out_q;

  assign first_pass = (a_q == '0);
  assign rb         = first_pass ? '0 : rmem_rdata;
  assign gt         = va_q > vmem_rdata;
  assign last_emit  = ({1'b0, k_q} == n_q - cnt_t'(1));
  assign out_load   = (state_q == ST_EWT) && (!out_vld_q || out_ready_i);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    n_d       = n_q;
    a_d       = a_q;
    b_d       = b_q;
    cb_d      = cb_q;
    va_d      = va_q;
    ra_d      = ra_q;
    k_d       = k_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    rd_en     = 1'b0;
    rd_addr   = a_q;
    vwr_en    = 1'b0;
    vwr_addr  = cnt_q[AddrBits-1:0];
    vwr_data  = in_req_i.value[ValueBits-1:0];
    rwr_en    = 1'b0;
    rwr_data  = rb + addr_t'(1);
    swr_en    = 1'b0;
    srd_en    = 1'b0;
    srd_addr  = k_q;

    // Drop the result once the receiver takes it
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          vwr_en = 1'b1;
          if (in_req_i.is_final || (cnt_q == cnt_t'(MaxItems - 1))) begin
            n_d     = cnt_q + cnt_t'(1);
            cnt_d   = '0;
            a_d     = '0;
            state_d = ST_HEAD;
          end else begin
            cnt_d = cnt_q + cnt_t'(1);
          end
        end
      end
      ST_HEAD: begin
        // Fetch element a and its rank gathered by earlier passes
        rd_en   = 1'b1;
        rd_addr = a_q;
        b_d     = {1'b0, a_q} + cnt_t'(1);
        state_d = ST_FIRST;
      end
      ST_FIRST: begin
        va_d = vmem_rdata;
        ra_d = rb;
        if (b_q < n_q) begin
          rd_en   = 1'b1;
          rd_addr = b_q[AddrBits-1:0];
          cb_d    = b_q[AddrBits-1:0];
          b_d     = b_q + cnt_t'(1);
          state_d = ST_RUN;
        end else begin
          state_d = ST_PUT;
        end
      end
      ST_RUN: begin
        // Compare a with cb; the larger one gains a rank step, cb on a tie.
        // The first pass writes every rank so stale entries never leak.
        if (gt) begin
          ra_d = ra_q + addr_t'(1);
        end
        rwr_en   = first_pass || !gt;
        rwr_data = gt ? rb : rb + addr_t'(1);
        if (b_q < n_q) begin
          rd_en   = 1'b1;
          rd_addr = b_q[AddrBits-1:0];
          cb_d    = b_q[AddrBits-1:0];
          b_d     = b_q + cnt_t'(1);
        end else begin
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        // Rank of a is final: place the value
        swr_en = 1'b1;
        if ({1'b0, a_q} == n_q - cnt_t'(1)) begin
          k_d     = '0;
          state_d = ST_ERD;
        end else begin
          a_d     = a_q + addr_t'(1);
          state_d = ST_HEAD;
        end
      end
      ST_ERD: begin
        srd_en   = 1'b1;
        srd_addr = k_q;
        state_d  = ST_EWT;
      end
      ST_EWT: begin
        // Hold until the output register is free
        if (out_load) begin
          out_vld_d              = 1'b1;
          out_d.sorted_value     = 16'(smem_rdata);
          out_d.end_of_set       = last_emit;
          k_d                    = k_q + addr_t'(1);
          state_d                = last_emit ? ST_LOAD : ST_ERD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      cnt_q     <= '0;
      n_q       <= '0;
      a_q       <= '0;
      b_q       <= '0;
      k_q       <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      n_q       <= n_d;
      a_q       <= a_d;
      b_q       <= b_d;
      k_q       <= k_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cb_q  <= cb_d;
    va_q  <= va_d;
    ra_q  <= ra_d;
    out_q <= out_d;
  end

  // Value memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (vwr_en) begin
      vmem[vwr_addr] <= vwr_data;
    end
    if (rd_en) begin
      vmem_rdata <= vmem[rd_addr];
    end
  end

  // Rank memory: written at the element being compared, read one ahead
  always_ff @(posedge clk_i) begin
    if (rwr_en) begin
      rmem[cb_q] <= rwr_data;
    end
    if (rd_en) begin
      rmem_rdata <= rmem[rd_addr];
    end
  end

  // Sorted store
  always_ff @(posedge clk_i) begin
    if (swr_en) begin
      smem[ra_q] <= va_q;
    end
    if (srd_en) begin
      smem_rdata <= smem[srd_addr];
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < cnt_t'(MaxItems))
    else $error("item count beyond store");

  a_final_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_req_i.is_final |=> state_q == ST_HEAD)
    else $error("final request did not start the sort");

  a_cmp_in_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> ({1'b0, cb_q} < n_q) && (cb_q > a_q))
    else $error("compare outside the set");

  a_rank_in_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PUT |-> {1'b0, ra_q} < n_q)
    else $error("rank outside the set");

endmodule
